// ===== src/cvkr_pkg.sv =====
// Shared constants and types for the Cyrillic Vigenere key recovery and decrypt block.
package cvkr_pkg;

  // Item kind carried on tuser of the input channel.
  typedef enum logic {
    KIND_LEARN   = 1'b0,
    KIND_DECRYPT = 1'b1
  } kind_t;

  // Windows-1251 Cyrillic letters occupy 192..255: the top two bits are set.
  localparam logic [1:0] LETTER_TAG = 2'b11;
  localparam int unsigned ALPHA_BITS = 5;

  typedef logic [ALPHA_BITS-1:0] shift_t;

  function automatic logic is_letter(input logic [7:0] b);
    return b[7:6] == LETTER_TAG;
  endfunction

  // Rotates a letter back by k inside its own 32-letter case range.
  function automatic logic [7:0] shift_back(input logic [7:0] b, input shift_t k);
    shift_t pos;
    pos = b[ALPHA_BITS-1:0] - k;
    if (is_letter(b)) begin
      return {b[7:ALPHA_BITS], pos};
    end
    return b;
  endfunction

endpackage

// ===== src/cyrillic_vigenere_key_recover_decrypt.sv =====
// Vigenere key recovery from a known-text line and decryption of later ciphertext.
//
// Input channel (in_*): one item per character byte. in_tuser is the item kind
// (0 learn pair, 1 ciphertext byte to decrypt), in_tlast marks the last byte of
// a line. A learn line pairs known plaintext with ciphertext; at its end the key
// becomes valid if every column got a consistent shift and no length mismatch
// was flagged. Any learn item makes the key invalid until its line closes.
// Output channel (out_*): one item per input item, with the decrypted byte (the
// cipher byte echoed on learn items or while no key is valid), the key valid
// flag on out_tuser and the line end copied to out_tlast.
// Throughput is one item per cycle while the receiver does not stall: the key
// table, the column counter and the learn flags are updated by a single subtract
// and compare on the registered input item, so each item sees the state left by
// the one before it. Items pass the input register, then the result register.
// Reset (synchronous, rst_n low) clears the key table, the learned marks, the
// flags, the column and the valid flags of both pipeline registers. When the
// receiver stalls, the result register holds, the input register fills and then
// in_tready drops; no item is lost or repeated.
module cyrillic_vigenere_key_recover_decrypt #(
  parameter int unsigned KEY_PERIOD = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // cipher_byte[7:0], plain_byte[15:8], pair_complete[16], zero
  input  logic [0:0]  in_tuser,   // kind[0]
  input  logic        in_tlast,   // line_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // out_byte[7:0]
  output logic [0:0]  out_tuser,  // key_valid[0]
  output logic        out_tlast   // line_last
);

  localparam int unsigned COL_W = (KEY_PERIOD > 1) ? $clog2(KEY_PERIOD) : 1;

  // Input register.
  logic                s1_valid_r;
  cvkr_pkg::kind_t     s1_kind_r;
  logic [7:0]          s1_cipher_r;
  logic [7:0]          s1_plain_r;
  logic                s1_complete_r;
  logic                s1_last_r;

  // Key state.
  cvkr_pkg::shift_t    key_shift_r [KEY_PERIOD];
  logic [KEY_PERIOD-1:0] shift_known_r, shift_known_nxt;
  logic                learn_failed_r, learn_failed_nxt;
  logic                key_ready_r, key_ready_nxt;
  logic [COL_W-1:0]    column_r, column_nxt;

  // Result register.
  logic                out_valid_r;
  logic [7:0]          out_byte_r, out_byte_nxt;
  logic                out_key_r;
  logic                out_last_r;

  logic                s1_fire;
  logic                learn_set;
  cvkr_pkg::shift_t    pair_shift;
  cvkr_pkg::shift_t    col_shift;

  assign s1_fire   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_fire;

  assign pair_shift = s1_cipher_r[cvkr_pkg::ALPHA_BITS-1:0]
                    - s1_plain_r[cvkr_pkg::ALPHA_BITS-1:0];
  assign col_shift  = key_shift_r[column_r];

  always_comb begin
    shift_known_nxt  = shift_known_r;
    learn_failed_nxt = learn_failed_r;
    key_ready_nxt    = key_ready_r;
    learn_set        = 1'b0;
    out_byte_nxt     = s1_cipher_r;

    if (s1_kind_r == cvkr_pkg::KIND_LEARN) begin
      key_ready_nxt = 1'b0;
      if (!s1_complete_r) begin
        learn_failed_nxt = 1'b1;
      end else if (cvkr_pkg::is_letter(s1_cipher_r) && cvkr_pkg::is_letter(s1_plain_r)) begin
        if (shift_known_r[column_r]) begin
          if (col_shift != pair_shift) begin
            learn_failed_nxt = 1'b1;
          end
        end else begin
          learn_set                 = 1'b1;
          shift_known_nxt[column_r] = 1'b1;
        end
      end
      // Closing the line decides the key and starts the next line fresh.
      if (s1_last_r) begin
        key_ready_nxt    = (&shift_known_nxt) && !learn_failed_nxt;
        shift_known_nxt  = '0;
        learn_failed_nxt = 1'b0;
      end
    end else if (key_ready_r) begin
      out_byte_nxt = cvkr_pkg::shift_back(s1_cipher_r, col_shift);
    end

    if (s1_last_r || (column_r == COL_W'(KEY_PERIOD - 1))) begin
      column_nxt = '0;
    end else begin
      column_nxt = column_r + COL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
    if (in_tready) begin
      s1_kind_r     <= cvkr_pkg::kind_t'(in_tuser[0]);
      s1_cipher_r   <= in_tdata[7:0];
      s1_plain_r    <= in_tdata[15:8];
      s1_complete_r <= in_tdata[16];
      s1_last_r     <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_known_r  <= '0;
      learn_failed_r <= 1'b0;
      key_ready_r    <= 1'b0;
      column_r       <= '0;
      for (int i = 0; i < KEY_PERIOD; i++) begin
        key_shift_r[i] <= '0;
      end
    end else if (s1_fire) begin
      shift_known_r  <= shift_known_nxt;
      learn_failed_r <= learn_failed_nxt;
      key_ready_r    <= key_ready_nxt;
      column_r       <= column_nxt;
      if (learn_set) begin
        key_shift_r[column_r] <= pair_shift;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (s1_fire) begin
      out_byte_r <= out_byte_nxt;
      out_key_r  <= key_ready_nxt;
      out_last_r <= s1_last_r;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_byte_r;
  assign out_tuser[0] = out_key_r;
  assign out_tlast    = out_last_r;

  a_column_range: assert property (@(posedge clk) disable iff (!rst_n)
    column_r <= COL_W'(KEY_PERIOD - 1))
    else $error("column counter left the key period");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> out_valid_r)
    else $error("processed item produced no result");

  a_line_close: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_last_r && s1_kind_r == cvkr_pkg::KIND_LEARN
      |=> column_r == '0 && shift_known_r == '0 && !learn_failed_r)
    else $error("line end did not reset the learn state");

  a_learn_blocks_key: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_kind_r == cvkr_pkg::KIND_LEARN && !s1_last_r |=> !key_ready_r)
    else $error("key valid in the middle of a learn line");

  a_no_key_echo: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_kind_r == cvkr_pkg::KIND_DECRYPT && !key_ready_r
      |=> out_byte_r == $past(s1_cipher_r))
    else $error("byte altered while no key is valid");

endmodule

// ===== tb/sv/tb_cyrillic_vigenere_key_recover_decrypt.sv =====
// Self-checking testbench for the Cyrillic Vigenere key recovery and decrypt block.
`timescale 1ns / 100ps

module tb_cyrillic_vigenere_key_recover_decrypt;

  localparam int PERIOD = 10;

  typedef struct {
    cvkr_pkg::kind_t kind;
    logic [7:0] cipher;
    logic [7:0] plain;
    logic       complete;
    logic       eol;
  } char_item_t;

  typedef struct {
    logic [7:0] out_byte;
    logic       key_valid;
    logic       line_last;
  } plain_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic [0:0]  in_tuser = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic [0:0]  out_tuser;
  logic        out_tlast;

  // Shadow copy of the key table and learn flags.
  logic [4:0]        learned_shift [PERIOD] = '{default: '0};
  logic [PERIOD-1:0] shift_set = '0;
  logic              line_bad = 1'b0;
  logic              key_live = 1'b0;
  logic [3:0]        pos = '0;

  plain_result_t awaited_out[$];
  int errors = 0;
  int items_sent = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_left = 0;

  cyrillic_vigenere_key_recover_decrypt #(.KEY_PERIOD(PERIOD)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  always #2 clk = ~clk;

  function automatic plain_result_t vigenere_predict(input char_item_t it);
    plain_result_t r;
    logic [4:0] s;
    logic [3:0] col;
    col = pos;
    r.out_byte = it.cipher;
    if (it.kind == cvkr_pkg::KIND_LEARN) begin
      key_live = 1'b0;
      if (!it.complete) begin
        line_bad = 1'b1;
      end else if (it.cipher >= 8'd192 && it.plain >= 8'd192) begin
        s = it.cipher[4:0] - it.plain[4:0];
        if (shift_set[col]) begin
          if (learned_shift[col] != s) line_bad = 1'b1;
        end else begin
          learned_shift[col] = s;
          shift_set[col] = 1'b1;
        end
      end
      if (it.eol) begin
        key_live = (&shift_set) && !line_bad;
        shift_set = '0;
        line_bad = 1'b0;
      end
    end else if (key_live && it.cipher >= 8'd192) begin
      // Letters rotate back inside their own case range; bit 5 picks the case.
      r.out_byte = {it.cipher[7:5], 5'(it.cipher[4:0] - learned_shift[col])};
    end
    pos = (it.eol || col == PERIOD - 1) ? 4'd0 : col + 4'd1;
    r.key_valid = key_live;
    r.line_last = it.eol;
    return r;
  endfunction

  function automatic logic [7:0] encipher(input logic lower, input logic [7:0] plain,
                                          input logic [4:0] k);
    return {2'b11, lower, 5'(plain[4:0] + k)};
  endfunction

  // Starts and ends at a falling edge; valid stays high into the next call.
  task automatic send_item(input cvkr_pkg::kind_t kind, input logic [7:0] cb,
                           input logic [7:0] pb, input logic comp, input logic last);
    char_item_t it;
    it = '{kind: kind, cipher: cb, plain: pb, complete: comp, eol: last};
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'b0, comp, pb, cb};
    in_tuser  <= kind;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    awaited_out.push_back(vigenere_predict(it));
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    wait (awaited_out.size() == 0);
    @(negedge clk);
  endtask

  task automatic send_learn_line();
    logic [4:0] key [PERIOD];
    logic [7:0] pb, cb;
    logic comp;
    int len, flaw, flaw_pos;
    foreach (key[i]) key[i] = 5'($urandom_range(31));
    flaw = $urandom_range(9);
    len = $urandom_range(PERIOD, 2 * PERIOD + 5);
    flaw_pos = $urandom_range(len - 1);
    for (int i = 0; i < len; i++) begin
      pb = {2'b11, 6'($urandom_range(63))};
      cb = encipher(1'($urandom_range(1)), pb, key[i % PERIOD]);
      comp = 1'b1;
      if (flaw == 0 && i == len - 1 && i >= PERIOD) begin
        cb[4:0] = cb[4:0] + 5'($urandom_range(1, 31));
      end else if (flaw == 1 && i == flaw_pos) begin
        comp = 1'b0;
      end else if (flaw == 2 && i == flaw_pos) begin
        if ($urandom_range(1)) pb = 8'($urandom_range(191));
        else cb = 8'($urandom_range(191));
      end
      send_item(cvkr_pkg::KIND_LEARN, cb, pb, comp, i == len - 1);
    end
  endtask

  task automatic send_cipher_line(input int len);
    logic [7:0] cb;
    for (int i = 0; i < len; i++) begin
      cb = ($urandom_range(99) < 85) ? {2'b11, 6'($urandom_range(63))}
                                     : 8'($urandom_range(255));
      send_item(cvkr_pkg::KIND_DECRYPT, cb, 8'($urandom_range(255)),
                1'($urandom_range(1)), i == len - 1);
    end
  endtask

  task automatic test_directed();
    logic [4:0] key [PERIOD] = '{5'd0, 5'd31, 5'd1, 5'd30, 5'd5, 5'd16, 5'd17, 5'd2,
                                 5'd9, 5'd20};
    logic [7:0] pb_list [12] = '{8'hC0, 8'hFF, 8'hDF, 8'hE0, 8'hC7, 8'hF3, 8'hD0,
                                 8'hEA, 8'hC1, 8'hEB, 8'hF5, 8'hC5};
    logic [11:0] lower_mask = 12'b0110_1010_1100;
    logic [7:0] probe [6] = '{8'hC0, 8'hDF, 8'hE0, 8'hFF, 8'hBF, 8'h00};
    send_idle_pct = 0;
    recv_idle_pct = 0;
    // No key yet: everything passes through.
    send_item(cvkr_pkg::KIND_DECRYPT, 8'h00, 8'hFF, 1'b1, 1'b0);
    send_item(cvkr_pkg::KIND_DECRYPT, 8'hFF, 8'h00, 1'b0, 1'b1);
    // Mixed-case learn line that wraps past the period, ending on a non-letter pair.
    for (int i = 0; i < 11; i++)
      send_item(cvkr_pkg::KIND_LEARN, encipher(lower_mask[i], pb_list[i], key[i % PERIOD]),
                pb_list[i], 1'b1, 1'b0);
    send_item(cvkr_pkg::KIND_LEARN, 8'hBF, pb_list[11], 1'b1, 1'b1);
    foreach (probe[i]) send_item(cvkr_pkg::KIND_DECRYPT, probe[i], 8'hFF, 1'b0, i == 5);
    // A length mismatch voids the line, and the key with it.
    send_item(cvkr_pkg::KIND_LEARN, 8'hC3, 8'hC3, 1'b0, 1'b0);
    send_item(cvkr_pkg::KIND_LEARN, 8'hE7, 8'hE2, 1'b1, 1'b1);
    send_item(cvkr_pkg::KIND_DECRYPT, 8'hE5, 8'h00, 1'b1, 1'b1);
    wait_drained();
  endtask

  task automatic test_long_stall();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_learn_line();
    in_tvalid <= 1'b0;
    @(posedge clk);
    stall_left = 80;
    @(negedge clk);
    send_cipher_line(40);
    wait_drained();
  endtask

  task automatic test_random_traffic(input int n_items, input int snd_pct, input int rcv_pct);
    int stop_at, pick;
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 20) begin
        send_learn_line();
      end else if (pick < 85) begin
        send_cipher_line($urandom_range(1, 30));
      end else begin
        repeat ($urandom_range(1, 8))
          send_item(cvkr_pkg::kind_t'($urandom_range(1)), 8'($urandom_range(255)),
                    8'($urandom_range(255)), 1'($urandom_range(1)),
                    $urandom_range(3) == 0);
      end
    end
    wait_drained();
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    plain_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (awaited_out.size() == 0) begin
        $display("%0t: unexpected result byte %02h key_valid %0b last %0b",
                 $time, out_tdata, out_tuser, out_tlast);
        errors++;
      end else begin
        exp_r = awaited_out.pop_front();
        if (out_tdata !== exp_r.out_byte) begin
          $display("%0t: out_byte expected %02h actual %02h",
                   $time, exp_r.out_byte, out_tdata);
          errors++;
        end
        if (out_tuser[0] !== exp_r.key_valid) begin
          $display("%0t: key_valid expected %0b actual %0b",
                   $time, exp_r.key_valid, out_tuser[0]);
          errors++;
        end
        if (out_tlast !== exp_r.line_last) begin
          $display("%0t: line_last expected %0b actual %0b",
                   $time, exp_r.line_last, out_tlast);
          errors++;
        end
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_long_stall();
    test_random_traffic(180, 13, 49);
    test_random_traffic(180, 49, 13);
    test_random_traffic(180, 0, 0);
    wait_drained();
    repeat (8) @(posedge clk);
    if (errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
